[sv/skrt_pkg.sv]
// Package for the sorted keyed record table: sizes, operation and status
// codes, and the record and cell control types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skrt_pkg;

	localparam int CAPACITY    = 16;
	localparam int KEY_BITS    = 8;
	localparam int AMOUNT_BITS = 27;
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
	localparam int OP_BITS     = 2;
	localparam int STATUS_BITS = 2;

	localparam logic [AMOUNT_BITS-1:0] AMOUNT_MAX = AMOUNT_BITS'(100000000);

	localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

	localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_DUP     = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_MISSING = 2'd2;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd3;

	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [AMOUNT_BITS-1:0] amount;
	} rec_t;

	typedef struct packed {
		logic                compare;
		logic [KEY_BITS-1:0] cmp_key;
		logic                insert;
		logic                remove;
		rec_t                new_rec;
	} cell_ctl_t;

endpackage

`default_nettype wire

[sv/skrt_cell.sv]
// One slot of the sorted record table: holds a record, compares it with the
// requested key and shifts records to and from its neighbors. Uses skrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skrt_cell
	import skrt_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      occupied,
	input  wire logic      prev_lt,
	input  wire rec_t      prev_rec,
	input  wire rec_t      next_rec,
	output rec_t           rec,
	output logic           lt,
	output logic           eq
);

	rec_t rec_q;
	logic lt_q;
	logic eq_q;

	always_ff @(posedge clk) begin
		if (ctl.compare) begin
			lt_q <= occupied && (rec_q.key < ctl.cmp_key);
			eq_q <= occupied && (rec_q.key == ctl.cmp_key);
		end
		if (ctl.insert && !lt_q) begin
			rec_q <= prev_lt ? ctl.new_rec : prev_rec;
		end else if (ctl.remove && !lt_q) begin
			rec_q <= next_rec;
		end
	end

	assign rec = rec_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

`default_nettype wire

[sv/sorted_keyed_record_table.sv]
// Top level of the sorted keyed record table: request and response channels,
// control sequencing and the row of skrt_cell slots. Uses skrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The table keeps up to CAPACITY key/amount records in ascending key order in
// a row of cells. In the cycle that a request item is accepted every cell
// compares its key with the requested key, and in the next cycle the status
// is formed from those flags and, on a successful insert or delete, every
// cell above the affected slot shifts one place toward or away from its
// neighbor. A new request is taken once the update cycle has passed; a
// stalled response holds the update cycle until the response register is
// free.
module sorted_keyed_record_table
	import skrt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire logic [OP_BITS-1:0]     operation,
	input  wire logic [KEY_BITS-1:0]    key,
	input  wire logic [AMOUNT_BITS-1:0] amount,
	output logic                        rsp_valid,
	input  wire logic                   rsp_stall,
	output logic [STATUS_BITS-1:0]      status,
	output logic [AMOUNT_BITS-1:0]      found_amount,
	output logic [COUNT_BITS-1:0]       entry_count
);

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t                 state_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [OP_BITS-1:0]     op_s1;
	rec_t                   new_rec_s1;
	logic                   rsp_valid_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [AMOUNT_BITS-1:0] found_q;

	cell_ctl_t              ctl;
	rec_t                   recs [CAPACITY];
	logic [CAPACITY-1:0]    lt_flags;
	logic [CAPACITY-1:0]    eq_flags;
	logic                   accept;
	logic                   commit;
	logic                   hit;
	logic                   full;
	logic [AMOUNT_BITS-1:0] found;
	logic                   insert_ok;
	logic                   remove_ok;
	logic [STATUS_BITS-1:0] status_d;

	assign req_stall = (state_q == ST_BUSY);
	assign accept    = req_valid && !req_stall;
	assign commit    = (state_q == ST_BUSY) && (!rsp_valid_q || !rsp_stall);
	assign hit       = |eq_flags;
	assign full      = (count_q == COUNT_BITS'(CAPACITY));
	assign insert_ok = (op_s1 == OP_INSERT) && !hit && !full;
	assign remove_ok = (op_s1 == OP_DELETE) && hit;

	always_comb begin
		found = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (eq_flags[i]) begin
				found = found | recs[i].amount;
			end
		end
	end

	always_comb begin
		case (op_s1) inside
			OP_INSERT: status_d = hit ? STATUS_DUP : (full ? STATUS_FULL : STATUS_OK);
			OP_LOOKUP, OP_DELETE: status_d = hit ? STATUS_OK : STATUS_MISSING;
			default: status_d = STATUS_MISSING;
		endcase
	end

	assign ctl.compare = accept;
	assign ctl.cmp_key = key;
	assign ctl.insert  = commit && insert_ok;
	assign ctl.remove  = commit && remove_ok;
	assign ctl.new_rec = new_rec_s1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skrt_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occupied (COUNT_BITS'(i) < count_q),
			.prev_lt  ((i == 0) ? 1'b1 : lt_flags[(i == 0) ? 0 : i - 1]),
			.prev_rec (recs[(i == 0) ? 0 : i - 1]),
			.next_rec (recs[(i == CAPACITY - 1) ? i : i + 1]),
			.rec      (recs[i]),
			.lt       (lt_flags[i]),
			.eq       (eq_flags[i])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1              <= operation;
			new_rec_s1.key     <= key;
			new_rec_s1.amount  <= (amount > AMOUNT_MAX) ? AMOUNT_MAX : amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (insert_ok) begin
							count_q <= count_q + 1'b1;
						end else if (remove_ok) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			found_q  <= ((op_s1 == OP_LOOKUP || op_s1 == OP_DELETE) && hit) ? found : '0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign found_amount = found_q;
	assign entry_count  = count_q;

endmodule

`default_nettype wire
